FILE: hdl/bmi_pkg.sv
// Package for the body motion integrator: transaction structs, action and
// register codes, and the saturating fixed-point helpers.
// No dependencies.
`default_nettype none
package bmi_pkg;

    // action codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_CAPPED = 2'd1;
    localparam logic [1:0] ACT_FREE   = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_GRAVITY  = 3'd0;
    localparam logic [2:0] REG_FRICTION = 3'd1;
    localparam logic [2:0] REG_MAX_SPD  = 3'd2;
    localparam logic [2:0] REG_WORLD    = 3'd3;
    localparam logic [2:0] REG_OBJECT   = 3'd4;

    // 0.1 in Q16.16
    localparam logic [31:0] TENTH_Q16 = 32'd6554;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        delta_time;
        logic signed [31:0] pos_in_x;
        logic signed [31:0] pos_in_y;
        logic signed [31:0] pos_in_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_out_x;
        logic signed [31:0] pos_out_y;
        logic signed [31:0] pos_out_z;
        logic signed [31:0] total_vel_x;
        logic signed [31:0] total_vel_y;
        logic signed [31:0] total_vel_z;
        logic               grounded;
    } t_out_item;

    // clip a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    // add two 32-bit values with saturation
    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(50'(a) + 50'(b));
    endfunction

    // v plus or minus a 48-bit magnitude, saturated
    function automatic logic signed [31:0] add_mag(input logic signed [31:0] v,
                                                   input logic [47:0] p,
                                                   input logic neg);
        logic signed [49:0] e;
        e = {2'b00, p};
        if (neg) begin
            e = -e;
        end
        return sat32(e + 50'(v));
    endfunction

    // magnitude of a signed 32-bit value, exact for the most negative code
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/body_motion_integrator.sv
// Body motion integrator top level: sequencer around one shared 32x32
// multiplier, a radix-2 square root iteration and a bit-serial divider.
// Depends on bmi_pkg.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+----------------------
//  in       | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//  cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A force action goes from ST_IDLE straight to ST_DONE; its result becomes
// valid from ST_DONE once the output register is free. In a tick, each
// horizontal length passes through the square root loop, each clamped
// component through the divider; zeroing a velocity skips its friction step.
// Reset clears velocities, the ground flag and loads the time scales with one.
// o_in_stall is high while a transaction is in work; the result sits in an
// output register; a stalled output only holds up the next transaction's end.
`default_nettype none
module body_motion_integrator import bmi_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DTW, ST_OS, ST_S, ST_F, ST_GRAV,
        ST_SQA, ST_SQB, ST_SQC, ST_SQRT, ST_LEN,
        ST_CLM, ST_DVI, ST_DIV,
        ST_FRM, ST_FRA, ST_PSM, ST_PSA, ST_GND, ST_DONE
    } t_state;

    typedef enum logic [1:0] {PH_CAP1, PH_CAP2, PH_FREE} t_phase;

    t_state r_state;
    t_phase r_phase;

    // configuration
    logic signed [31:0] r_gravity;
    logic [15:0]        r_friction;
    logic [30:0]        r_max_spd;
    logic [15:0]        r_world;
    logic [15:0]        r_object;

    // body state and working registers
    logic signed [31:0] r_cv [3];
    logic signed [31:0] r_fv [3];
    logic signed [31:0] r_pos [3];
    logic               r_ground;
    logic [15:0]        r_dt;
    logic [31:0]        r_s;
    logic [31:0]        r_f;
    logic [63:0]        r_prod;
    logic [63:0]        r_acc;
    logic [63:0]        r_rad;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_num;
    logic [31:0]        r_len;
    logic [4:0]         r_cnt;
    logic [1:0]         r_idx;
    logic               r_kill;
    logic               r_neg;
    logic               r_ovalid;
    t_out_item          r_out;

    // shared multiplier operands
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic signed [31:0] w_va, w_va0, w_va2, w_tv;
    logic [35:0] w_sq_t, w_sq_trial;
    logic        w_sq_ge;
    logic [32:0] w_dv_t;
    logic        w_dv_ge;
    logic        w_in_acc;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // select the vector being worked on
    assign w_va0 = (r_phase == PH_FREE) ? r_fv[0] : r_cv[0];
    assign w_va2 = (r_phase == PH_FREE) ? r_fv[2] : r_cv[2];
    assign w_va  = (r_phase == PH_FREE) ? r_fv[r_idx] : r_cv[r_idx];
    assign w_tv  = add_sat(r_cv[r_idx], r_fv[r_idx]);

    // route operands into the multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_DTW: begin
                w_ma = {16'd0, r_dt};
                w_mb = {16'd0, r_world};
            end
            ST_OS: begin
                w_ma = r_prod[31:0];
                w_mb = {16'd0, r_object};
            end
            ST_S: begin
                w_ma = r_prod[47:16];
                w_mb = {16'd0, r_friction};
            end
            ST_F: begin
                w_ma = mag32(r_gravity);
                w_mb = r_s;
            end
            ST_SQA: begin
                w_ma = mag32(w_va0);
                w_mb = mag32(w_va0);
            end
            ST_SQB: begin
                w_ma = mag32(w_va2);
                w_mb = mag32(w_va2);
            end
            ST_CLM: begin
                w_ma = mag32(r_cv[r_idx]);
                w_mb = {1'b0, r_max_spd};
            end
            ST_FRM: begin
                w_ma = mag32(w_va);
                w_mb = r_f;
            end
            ST_PSM: begin
                w_ma = mag32(w_tv);
                w_mb = r_s;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // square root digit and divider bit
    assign w_sq_t     = {r_rem, r_rad[63:62]};
    assign w_sq_trial = {2'b00, r_root, 2'b01};
    assign w_sq_ge    = (w_sq_t >= w_sq_trial);
    assign w_dv_t     = {r_rem[31:0], r_num[31]};
    assign w_dv_ge    = (w_dv_t >= {1'b0, r_len});

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_CAP1;
            r_gravity  <= '0;
            r_friction <= '0;
            r_max_spd  <= '0;
            r_world    <= 16'd256;
            r_object   <= 16'd256;
            r_cv       <= '{default: '0};
            r_fv       <= '{default: '0};
            r_ground   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
            r_cnt      <= '0;
        end else begin
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_GRAVITY:  r_gravity  <= i_cfg_data;
                    REG_FRICTION: r_friction <= i_cfg_data[15:0];
                    REG_MAX_SPD:  r_max_spd  <= i_cfg_data[30:0];
                    REG_WORLD:    r_world    <= i_cfg_data[15:0];
                    REG_OBJECT:   r_object   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // raise valid on a new result, drop it once taken
            if (r_state == ST_DONE && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_dt     <= i_in_data.delta_time;
                        r_pos[0] <= i_in_data.pos_in_x;
                        r_pos[1] <= i_in_data.pos_in_y;
                        r_pos[2] <= i_in_data.pos_in_z;
                        r_phase  <= PH_CAP1;
                        if (i_in_data.action == ACT_CAPPED) begin
                            r_cv[0] <= add_sat(r_cv[0], i_in_data.force_x);
                            r_cv[1] <= add_sat(r_cv[1], i_in_data.force_y);
                            r_cv[2] <= add_sat(r_cv[2], i_in_data.force_z);
                        end else if (i_in_data.action == ACT_FREE) begin
                            r_fv[0] <= add_sat(r_fv[0], i_in_data.force_x);
                            r_fv[1] <= add_sat(r_fv[1], i_in_data.force_y);
                            r_fv[2] <= add_sat(r_fv[2], i_in_data.force_z);
                        end
                        r_state <= (i_in_data.action == ACT_TICK) ? ST_DTW : ST_DONE;
                    end
                end
                // time scale and friction step
                ST_DTW: begin
                    r_prod  <= w_prod;
                    r_state <= ST_OS;
                end
                ST_OS: begin
                    r_prod  <= w_prod;
                    r_state <= ST_S;
                end
                ST_S: begin
                    r_s     <= r_prod[47:16];
                    r_prod  <= w_prod;
                    r_state <= ST_F;
                end
                ST_F: begin
                    r_f     <= r_prod[47:16];
                    r_prod  <= w_prod;
                    r_state <= ST_GRAV;
                end
                ST_GRAV: begin
                    r_cv[1] <= add_mag(r_cv[1], r_prod[63:16], r_gravity[31]);
                    r_state <= ST_SQA;
                end
                // horizontal length: squares, then the root
                ST_SQA: begin
                    r_prod  <= w_prod;
                    r_state <= ST_SQB;
                end
                ST_SQB: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_prod;
                    r_state <= ST_SQC;
                end
                ST_SQC: begin
                    r_rad   <= r_acc + r_prod;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= 5'd31;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_rad <= {r_rad[61:0], 2'b00};
                    if (w_sq_ge) begin
                        r_rem  <= 34'(w_sq_t - w_sq_trial);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= w_sq_t[33:0];
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    r_len <= r_root;
                    r_idx <= 2'd0;
                    if (r_phase == PH_CAP1 && r_root > {1'b0, r_max_spd}) begin
                        r_state <= ST_CLM;
                    end else begin
                        if (r_phase == PH_FREE) begin
                            r_kill <= !(r_root > r_f);
                        end else begin
                            r_kill <= !(r_root > TENTH_Q16);
                        end
                        r_phase <= (r_phase == PH_FREE) ? PH_FREE : PH_CAP2;
                        r_state <= ST_FRM;
                    end
                end
                // clamp one capped component to the speed limit
                ST_CLM: begin
                    r_prod  <= w_prod;
                    r_neg   <= r_cv[r_idx][31];
                    r_state <= ST_DVI;
                end
                ST_DVI: begin
                    r_rem   <= {2'b00, r_prod[63:32]};
                    r_num   <= r_prod[31:0];
                    r_cnt   <= 5'd31;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= {2'b00, w_dv_ge ? 32'(w_dv_t - {1'b0, r_len}) : w_dv_t[31:0]};
                    r_num <= {r_num[30:0], w_dv_ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_cv[r_idx] <= r_neg ? -$signed({r_num[30:0], w_dv_ge})
                                             : $signed({r_num[30:0], w_dv_ge});
                        if (r_idx == 2'd0) begin
                            r_idx   <= 2'd2;
                            r_state <= ST_CLM;
                        end else begin
                            r_phase <= PH_CAP2;
                            r_state <= ST_SQA;
                        end
                    end
                end
                // friction, or zero when too slow
                ST_FRM: begin
                    if (r_kill) begin
                        if (r_phase == PH_FREE) begin
                            r_fv[0] <= '0;
                            r_fv[2] <= '0;
                            r_idx   <= 2'd0;
                            r_state <= ST_PSM;
                        end else begin
                            r_cv[0] <= '0;
                            r_cv[2] <= '0;
                            r_phase <= PH_FREE;
                            r_state <= ST_SQA;
                        end
                    end else begin
                        r_prod  <= w_prod;
                        r_neg   <= w_va[31];
                        r_state <= ST_FRA;
                    end
                end
                ST_FRA: begin
                    if (r_phase == PH_FREE) begin
                        r_fv[r_idx] <= add_mag(r_fv[r_idx], r_prod[63:16], !r_neg);
                    end else begin
                        r_cv[r_idx] <= add_mag(r_cv[r_idx], r_prod[63:16], !r_neg);
                    end
                    if (r_idx == 2'd0) begin
                        r_idx   <= 2'd2;
                        r_state <= ST_FRM;
                    end else if (r_phase == PH_FREE) begin
                        r_idx   <= 2'd0;
                        r_state <= ST_PSM;
                    end else begin
                        r_phase <= PH_FREE;
                        r_state <= ST_SQA;
                    end
                end
                // advance the position one axis at a time
                ST_PSM: begin
                    r_prod  <= w_prod;
                    r_neg   <= w_tv[31];
                    r_state <= ST_PSA;
                end
                ST_PSA: begin
                    r_pos[r_idx] <= add_mag(r_pos[r_idx], r_prod[63:16], r_neg);
                    if (r_idx == 2'd2) begin
                        r_state <= ST_GND;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= ST_PSM;
                    end
                end
                // ground contact
                ST_GND: begin
                    if (r_pos[1] <= 32'sd0) begin
                        r_pos[1] <= '0;
                        r_cv[1]  <= '0;
                        r_fv[1]  <= '0;
                        r_ground <= 1'b1;
                    end else begin
                        r_ground <= 1'b0;
                    end
                    r_state <= ST_DONE;
                end
                // hand the result to the output register once it is free
                ST_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out.pos_out_x   <= r_pos[0];
                        r_out.pos_out_y   <= r_pos[1];
                        r_out.pos_out_z   <= r_pos[2];
                        r_out.total_vel_x <= add_sat(r_cv[0], r_fv[0]);
                        r_out.total_vel_y <= add_sat(r_cv[1], r_fv[1]);
                        r_out.total_vel_z <= add_sat(r_cv[2], r_fv[2]);
                        r_out.grounded    <= r_ground;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a waiting result is neither lost nor altered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> (r_ovalid && $stable(r_out)))
        else $error("result changed while stalled");

    // force actions finish without the arithmetic sequence
    a_force_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.action != ACT_TICK) |=> (r_state == ST_DONE))
        else $error("force action entered the tick sequence");

    // the root loop ends after its last digit
    a_sqrt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT && r_cnt == 5'd0) |=> (r_state == ST_LEN))
        else $error("square root loop overran");

endmodule
`default_nettype wire
